/* rtl/core/signed_binary_to_decimal_ascii_assert.svh */
// assertion macros for the decimal text block and its checker
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, held off during reset
`define SBDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbda check failed");

// next-cycle implication, held off during reset
`define SBDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbda check failed");

`endif

/* rtl/core/sbda_pkg.sv */
package sbda_pkg;

  localparam int NumDigits = 19;
  localparam int ValueW    = 64;
  localparam int CntW      = 5;
  localparam int BitCntW   = $clog2(ValueW);

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2d;

  typedef struct packed {
    logic clr;
    logic conv;
    logic shd;
  } cell_ctl_t;

endpackage

/* rtl/core/sbda_cell.sv */
module sbda_cell import sbda_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       bit_in,
  input  logic [3:0] dig_in,
  output logic       bit_out,
  output logic [3:0] dig_out
);

  logic [3:0] dig_r;
  logic [3:0] dig_nxt;
  logic [3:0] adj;

  // add three before the doubling so the digit carries at ten
  assign adj     = (dig_r >= 4'd5) ? (dig_r + 4'd3) : dig_r;
  assign bit_out = adj[3];
  assign dig_out = dig_r;

  always_comb begin
    dig_nxt = dig_r;
    if (ctl.clr) begin
      dig_nxt = 4'd0;
    end else if (ctl.conv) begin
      dig_nxt = {adj[2:0], bit_in};
    end else if (ctl.shd) begin
      dig_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

endmodule

/* rtl/core/signed_binary_to_decimal_ascii.sv */
// Signed 64-bit integer to decimal ASCII text.
// Input channel: in_value with in_valid/in_ready; one request is taken
// whenever the block is idle, even while its final character still waits.
// Result channel: the characters of each request on out_*, most significant
// first, with out_text_length (whole text) on each and out_last_char on the final one.
// Negative values start with '-'; zero gives "0"; the most negative value
// gives "-9223372036854775808".
// Conversion runs a row of 19 decimal digit cells, shift-and-add-three,
// one magnitude bit per cycle. Leading zero digits are then shifted out
// of the top cell, one per cycle (up to 18), and characters leave through
// a single output register, one per cycle while the receiver is ready.
// The first character follows acceptance after the 64-step digit-cell loop
// and the shift past leading zero digits; a new request is taken only once
// the final character has been loaded into the output register.
// A stalled receiver holds the output register; the cells wait with it.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
module signed_binary_to_decimal_ascii import sbda_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_text_char,
  output logic [CntW-1:0]          out_text_length,
  output logic                     out_last_char
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [ValueW-1:0]  mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [BitCntW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CntW-1:0]    ndig_r, ndig_nxt;
  logic [CntW-1:0]    len_r, len_nxt;
  logic               sign_pend_r, sign_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic [CntW-1:0]    out_len_r, out_len_nxt;
  logic               out_last_r, out_last_nxt;
  logic [ValueW-1:0]  raw;
  cell_ctl_t          ctl;
  logic [3:0]         top_dig;

  logic [NumDigits-1:0] carry;
  logic [3:0]           dig [NumDigits];

  assign raw      = ValueW'(in_value);
  assign in_ready = (state_r == StIdle);
  assign carry[0] = mag_r[ValueW-1];
  assign top_dig  = dig[NumDigits-1];

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_low
      sbda_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (carry[i]),
        .dig_in  (4'd0),
        .bit_out (carry[i+1]),
        .dig_out (dig[i])
      );
    end else if (i == NumDigits - 1) begin : g_top
      sbda_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (carry[i]),
        .dig_in  (dig[i-1]),
        .bit_out (),
        .dig_out (dig[i])
      );
    end else begin : g_mid
      sbda_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (carry[i]),
        .dig_in  (dig[i-1]),
        .bit_out (carry[i+1]),
        .dig_out (dig[i])
      );
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    ndig_nxt      = ndig_r;
    len_nxt       = len_r;
    sign_pend_nxt = sign_pend_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          neg_nxt     = raw[ValueW-1];
          mag_nxt     = raw[ValueW-1] ? (~raw + ValueW'(1)) : raw;
          bit_cnt_nxt = BitCntW'(ValueW - 1);
          ctl.clr     = 1'b1;
          state_nxt   = StConv;
        end
      end
      StConv: begin
        ctl.conv = 1'b1;
        mag_nxt  = {mag_r[ValueW-2:0], 1'b0};
        if (bit_cnt_r == '0) begin
          ndig_nxt  = CntW'(NumDigits);
          state_nxt = StSkip;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BitCntW'(1);
        end
      end
      StSkip: begin
        // drop leading zero digits, keep at least one
        if (top_dig == 4'd0 && ndig_r != CntW'(1)) begin
          ctl.shd  = 1'b1;
          ndig_nxt = ndig_r - CntW'(1);
        end else begin
          len_nxt       = ndig_r + CntW'(neg_r);
          sign_pend_nxt = neg_r;
          state_nxt     = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = len_r;
          if (sign_pend_r) begin
            out_char_nxt  = ChMinus;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = ChZero + {4'd0, top_dig};
            out_last_nxt = (ndig_r == CntW'(1));
            ctl.shd      = 1'b1;
            ndig_nxt     = ndig_r - CntW'(1);
            if (ndig_r == CntW'(1)) begin
              state_nxt = StIdle;
            end
          end
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    ndig_r      <= ndig_nxt;
    len_r       <= len_nxt;
    sign_pend_r <= sign_pend_nxt;
    out_char_r  <= out_char_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_text_char   = out_char_r;
  assign out_text_length = out_len_r;
  assign out_last_char   = out_last_r;

endmodule

/* rtl/core/sbda_checker.sv */
`include "signed_binary_to_decimal_ascii_assert.svh"

module sbda_checker import sbda_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic signed [ValueW-1:0] in_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [7:0]               out_text_char,
  input logic [CntW-1:0]          out_text_length,
  input logic                     out_last_char
);

  logic is_digit;

  assign is_digit = (out_text_char >= ChZero) && (out_text_char <= ChZero + 8'd9);

  // a stalled character is held with all its fields
  `SBDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_text_char) && $stable(out_text_length)
    && $stable(out_last_char))

  // only a sign or a digit ever leaves
  `SBDA_ASSERT_NOW(a_char_kind, out_valid, is_digit || out_text_char == ChMinus)

  // length stays within one to twenty, and a sign never ends the text
  `SBDA_ASSERT_NOW(a_len_range, out_valid,
    out_text_length >= CntW'(1) && out_text_length <= CntW'(20)
    && !(out_text_char == ChMinus && out_last_char))

  // an accepted request leaves idle, so no second request right behind the first
  `SBDA_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready && $stable(in_value),
    !in_ready)

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (.*);
